### src/pta_pkg.sv
// Shared types, codes and constants for the page table address translator.
package pta_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;

    localparam int VA_W      = 16;
    localparam int PSIZE_W   = 16;
    localparam int PCOUNT_W  = 9;
    localparam int FCOUNT_W  = 9;
    localparam int PAGE_W    = 8;
    localparam int FNUM_W    = 9;
    localparam int FRAME_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int PA_W      = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_STEPS = VA_W;
    localparam int MUL_STEPS = FRAME_W;

    localparam logic [PSIZE_W-1:0]  PAGE_SIZE_RESET   = 16'd256;
    localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RESET  = 9'd256;
    localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RESET = 9'd256;

    localparam logic [FNUM_W-1:0] FRAME_UNMAPPED = 9'h1FF;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_WRITTEN    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRANSLATED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_INVALID    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FAULT      = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WCHECK,
        S_SCAN,
        S_WFIN,
        S_TCHECK,
        S_DIV,
        S_TLIMIT,
        S_TREAD,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        ARITH_HOLD,
        ARITH_LOAD_DIV,
        ARITH_DIV_STEP,
        ARITH_LOAD_MUL,
        ARITH_MUL_STEP,
        ARITH_ADD_OFF
    } arith_op_t;

    typedef struct packed {
        arith_op_t          op;
        logic [FRAME_W-1:0] frame;
    } arith_ctrl_t;

    typedef struct packed {
        logic [VA_W-1:0] quotient;
        logic [PA_W-1:0] result;
    } arith_res_t;

endpackage

### src/pta_if.sv
// Valid/ready channel interfaces for translator requests and results.
interface pta_in_if
    import pta_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [PAGE_W-1:0]        page_index;
    logic signed [FNUM_W-1:0] frame_number;
    logic [VA_W-1:0]          virtual_address;

    modport source (output valid, operation, page_index, frame_number, virtual_address,
                    input ready);
    modport sink   (input valid, operation, page_index, frame_number, virtual_address,
                    output ready);
endinterface

interface pta_out_if
    import pta_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     physical_address;

    modport source (output valid, status, physical_address, input ready);
    modport sink   (input valid, status, physical_address, output ready);
endinterface

### src/pta_arith.sv
// Shared add/subtract unit with its working registers for division and multiplication.
module pta_arith
    import pta_pkg::*;
(
    input  logic                clk,
    input  arith_ctrl_t         ctrl,
    input  logic [VA_W-1:0]     dividend,
    input  logic [PSIZE_W-1:0]  divisor,
    output arith_res_t          res
);

    logic [PA_W-1:0]    work_reg, work_next;
    logic [VA_W-1:0]    quo_reg, quo_next;
    logic [PSIZE_W-1:0] off_reg, off_next;

    logic [PA_W-1:0] op_a, op_b;
    logic            sub;
    logic [PA_W:0]   total;
    logic            carry;
    logic [PA_W-1:0] sum;
    logic [VA_W:0]   rem_sh;

    assign rem_sh = {work_reg[VA_W-1:0], quo_reg[VA_W-1]};

    // Operand selection for the single adder.
    always_comb
    begin
        op_a = work_reg;
        op_b = '0;
        sub  = 1'b0;
        unique case (ctrl.op)
            ARITH_DIV_STEP:
            begin
                op_a = PA_W'(rem_sh);
                op_b = PA_W'(divisor);
                sub  = 1'b1;
            end
            ARITH_MUL_STEP:
            begin
                op_a = {work_reg[PA_W-2:0], 1'b0};
                op_b = quo_reg[VA_W-1] ? PA_W'(divisor) : '0;
            end
            ARITH_ADD_OFF:
            begin
                op_b = PA_W'(off_reg);
            end
            default:
            begin
                op_a = work_reg;
            end
        endcase
    end

    assign total = {1'b0, op_a} + {1'b0, op_b ^ {PA_W{sub}}} + (PA_W+1)'(sub);
    assign carry = total[PA_W];
    assign sum   = total[PA_W-1:0];

    always_comb
    begin
        work_next = work_reg;
        quo_next  = quo_reg;
        off_next  = off_reg;
        unique case (ctrl.op)
            ARITH_LOAD_DIV:
            begin
                work_next = '0;
                quo_next  = dividend;
            end
            ARITH_DIV_STEP:
            begin
                // Restoring division: keep the difference only when it did not borrow.
                work_next = carry ? sum : PA_W'(rem_sh);
                quo_next  = {quo_reg[VA_W-2:0], carry};
            end
            ARITH_LOAD_MUL:
            begin
                off_next  = work_reg[PSIZE_W-1:0];
                work_next = '0;
                quo_next  = {ctrl.frame, {(VA_W-FRAME_W){1'b0}}};
            end
            ARITH_MUL_STEP:
            begin
                work_next = sum;
                quo_next  = {quo_reg[VA_W-2:0], 1'b0};
            end
            ARITH_ADD_OFF:
            begin
                work_next = sum;
            end
            default:
            begin
                work_next = work_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        quo_reg  <= quo_next;
        off_reg  <= off_next;
    end

    assign res.quotient = quo_reg;
    assign res.result   = work_reg;

endmodule

### src/page_table_address_translator_top.sv
// Top level of the single-level page table address translator.
//
// The block keeps one entry per page in an internal memory of TABLE_DEPTH words; each word
// holds a mapped flag and an 8-bit frame. After reset a clearing pass marks every entry
// unmapped, one entry per cycle, during which no transaction is accepted on the request
// channel (configuration writes are taken throughout). Requests are handled one at a time.
// A table write whose frame is checked for duplicates runs a scan over every memory entry
// at one read per cycle; writes rejected by the range checks and unmappings skip the scan.
// A translation of a mapped page takes 16 restoring division steps on the shared adder,
// one table read, 8 shift-and-add multiply steps and an offset add on the same adder;
// invalid addresses and page faults finish earlier. A new request is accepted while a
// finished result still waits on the result channel.
module page_table_address_translator_top
    import pta_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pta_in_if.sink                in_ch,
    pta_out_if.source             out_ch
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int LIM_W = VA_W + 1;
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(TABLE_DEPTH);

    // Configuration registers.
    logic [PSIZE_W-1:0]  page_size_reg;
    logic [PCOUNT_W-1:0] page_count_reg;
    logic [FCOUNT_W-1:0] frame_count_reg;

    // Sequencer and request registers.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [4:0]          step_reg, step_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                dup_reg, dup_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [FNUM_W-1:0]   frame_reg, frame_next;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [PA_W-1:0]     out_pa_reg, out_pa_next;

    // Table memory.
    logic [FRAME_W:0]    mem [TABLE_DEPTH];
    logic [FRAME_W:0]    rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [FRAME_W:0]    mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;

    arith_ctrl_t         arith_ctrl;
    arith_res_t          arith_res;

    logic                in_fire;
    logic                out_free;
    logic [LIM_W-1:0]    page_limit;
    logic [IDX_W-1:0]    page_idx;
    logic                page_ok;
    logic                frame_unmap;
    logic                frame_ok;
    logic                scan_done;
    logic                clear_last;
    logic                div_last;
    logic                mul_last;
    logic                quo_ok;
    logic                entry_match;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.status           = out_status_reg;
    assign out_ch.physical_address = out_pa_reg;

    // Pages at or beyond the smaller of page_count and the table depth are out of range.
    assign page_limit = (LIM_W'(page_count_reg) < DEPTH_L) ? LIM_W'(page_count_reg) : DEPTH_L;
    assign page_idx   = IDX_W'(page_reg);
    assign page_ok    = LIM_W'(page_reg) < page_limit;
    assign frame_unmap = (frame_reg == FRAME_UNMAPPED);
    assign frame_ok   = !frame_reg[FNUM_W-1]
                        && (FCOUNT_W'(frame_reg[FRAME_W-1:0]) < frame_count_reg);
    assign scan_done  = (cnt_reg == CNT_W'(TABLE_DEPTH)) && !rd_pend_reg;
    assign clear_last = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));
    assign div_last   = (step_reg == 5'(DIV_STEPS - 1));
    assign mul_last   = (step_reg == 5'(MUL_STEPS - 1));
    assign quo_ok     = LIM_W'(arith_res.quotient) < page_limit;

    // A mapped entry other than the page being written that already holds the frame.
    assign entry_match = rd_data_reg[FRAME_W]
                         && (rd_data_reg[FRAME_W-1:0] == frame_reg[FRAME_W-1:0])
                         && (rd_idx_reg != page_idx);

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= PAGE_SIZE_RESET;
            page_count_reg  <= PAGE_COUNT_RESET;
            frame_count_reg <= FRAME_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PAGE_SIZE:   page_size_reg   <= cfg_data[PSIZE_W-1:0];
                CFG_PAGE_COUNT:  page_count_reg  <= cfg_data[PCOUNT_W-1:0];
                CFG_FRAME_COUNT: frame_count_reg <= cfg_data[FCOUNT_W-1:0];
                default:         page_size_reg   <= page_size_reg;
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                    state_next = in_ch.operation ? S_TCHECK : S_WCHECK;
            end
            S_WCHECK:
            begin
                priority if (!page_ok)
                    state_next = S_DONE;
                else if (frame_unmap)
                    state_next = S_DONE;
                else if (!frame_ok)
                    state_next = S_DONE;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = S_WFIN;
            end
            S_WFIN:
            begin
                state_next = S_DONE;
            end
            S_TCHECK:
            begin
                state_next = (page_size_reg == '0) ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (div_last)
                    state_next = S_TLIMIT;
            end
            S_TLIMIT:
            begin
                state_next = quo_ok ? S_TREAD : S_DONE;
            end
            S_TREAD:
            begin
                state_next = rd_data_reg[FRAME_W] ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                if (mul_last)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control and register next values.
    always_comb
    begin
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        dup_next        = dup_reg;
        page_next       = page_reg;
        frame_next      = frame_reg;
        va_next         = va_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_pa_next     = out_pa_reg;
        mem_we          = 1'b0;
        mem_waddr       = page_idx;
        mem_wdata       = '0;
        mem_raddr       = arith_res.quotient[IDX_W-1:0];
        arith_ctrl.op    = ARITH_HOLD;
        arith_ctrl.frame = rd_data_reg[FRAME_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[IDX_W-1:0];
                mem_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    page_next  = in_ch.page_index;
                    frame_next = in_ch.frame_number;
                    va_next    = in_ch.virtual_address;
                end
            end
            S_WCHECK:
            begin
                cnt_next = '0;
                dup_next = 1'b0;
                priority if (!page_ok)
                    status_next = STATUS_REJECTED;
                else if (frame_unmap)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = '0;
                    status_next = STATUS_WRITTEN;
                end
                else if (!frame_ok)
                    status_next = STATUS_REJECTED;
                else
                    status_next = status_reg;
            end
            S_SCAN:
            begin
                // One read issued per cycle; the read word is registered before it is compared.
                if (cnt_reg != CNT_W'(TABLE_DEPTH))
                begin
                    mem_raddr    = cnt_reg[IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (rd_pend_reg && entry_match)
                    dup_next = 1'b1;
            end
            S_WFIN:
            begin
                if (dup_reg)
                    status_next = STATUS_REJECTED;
                else
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = {1'b1, frame_reg[FRAME_W-1:0]};
                    status_next = STATUS_WRITTEN;
                end
            end
            S_TCHECK:
            begin
                step_next = '0;
                if (page_size_reg == '0)
                    status_next = STATUS_INVALID;
                else
                    arith_ctrl.op = ARITH_LOAD_DIV;
            end
            S_DIV:
            begin
                arith_ctrl.op = ARITH_DIV_STEP;
                step_next     = step_reg + 1'b1;
            end
            S_TLIMIT:
            begin
                mem_raddr = arith_res.quotient[IDX_W-1:0];
                if (!quo_ok)
                    status_next = STATUS_INVALID;
            end
            S_TREAD:
            begin
                step_next = '0;
                if (rd_data_reg[FRAME_W])
                    arith_ctrl.op = ARITH_LOAD_MUL;
                else
                    status_next = STATUS_FAULT;
            end
            S_MUL:
            begin
                arith_ctrl.op = ARITH_MUL_STEP;
                step_next     = step_reg + 1'b1;
            end
            S_ADD:
            begin
                arith_ctrl.op = ARITH_ADD_OFF;
                status_next   = STATUS_TRANSLATED;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_pa_next     = (status_reg == STATUS_TRANSLATED) ? arith_res.result : '0;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            step_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            rd_pend_reg   <= rd_pend_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        page_reg       <= page_next;
        frame_reg      <= frame_next;
        va_reg         <= va_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_pa_reg     <= out_pa_next;
    end

    // Table memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // The shared arithmetic unit performs the division and the multiplication.
    pta_arith u_arith (
        .clk      (clk),
        .ctrl     (arith_ctrl),
        .dividend (va_reg),
        .divisor  (page_size_reg),
        .res      (arith_res)
    );

    // Only translations carry an address; every other result reports zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.status != STATUS_TRANSLATED) |-> out_ch.physical_address == '0)
        else $error("non-translated result carries a physical address");

    // The table is only written by the clearing pass, an unmapping or a committed write.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR) || (state_reg == S_WCHECK) || (state_reg == S_WFIN))
        else $error("table written outside a write transaction");

    // A write that found the frame elsewhere in the table must not be committed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WFIN) && dup_reg |-> !mem_we)
        else $error("duplicate frame committed to the table");

    // No request is taken while the table is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ch.ready)
        else $error("request accepted during the clearing pass");

endmodule

### verif/page_table_address_translator_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the page table address translator: directed and random traffic.
module page_table_address_translator_top_test;
    import pta_pkg::*;

    // The block is built with its default depth, so the shadow table is that deep too.
    localparam int DEPTH       = TABLE_DEPTH_DEFAULT;
    // The limit covers the slowest correct run, about 2000 transactions each of a full duplicate
    // scan plus the longest stall on both sides, with a factor of five to spare.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PRINT_CAP   = 100;

    localparam logic OP_MAP       = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // Index 3 names no register; a write to it must leave the geometry alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                     op;
        logic [PAGE_W-1:0]        page;
        logic signed [FNUM_W-1:0] frame;
        logic [VA_W-1:0]          va;
    } pt_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PA_W-1:0]     address;
    } pt_response_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pta_in_if  req_ch();
    pta_out_if res_ch();

    page_table_address_translator_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (req_ch),
        .out_ch    (res_ch)
    );

    // Shadow copy of the page table and of the geometry registers.
    logic               shadow_mapped [DEPTH];
    logic [FRAME_W-1:0] shadow_frame [DEPTH];
    logic [PSIZE_W-1:0]  shadow_page_size;
    logic [PCOUNT_W-1:0] shadow_page_count;
    logic [FCOUNT_W-1:0] shadow_frame_count;

    pt_request_t  request_backlog [$];
    pt_response_t awaited_responses [$];
    int unsigned  touched_pages [$];

    pt_request_t  next_req;
    pt_response_t wanted;

    int  error_count   = 0;
    int  cycle_count   = 0;
    int  src_idle_left = 0;
    int  snk_idle_left = 0;
    bit  idling_on     = 1'b1;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Works out the answer of the table to one transaction and applies any table update.
    function automatic pt_response_t predict_response(pt_request_t rq);
        pt_response_t rs;
        int unsigned  lim;
        int           fn;
        int unsigned  pn;
        int unsigned  phys;
        bit           clash;
        rs.status  = STATUS_WRITTEN;
        rs.address = '0;
        lim = (shadow_page_count > DEPTH) ? DEPTH : shadow_page_count;
        if (rq.op == OP_MAP)
        begin
            fn = int'($signed(rq.frame));
            if (rq.page >= lim)
                rs.status = STATUS_REJECTED;
            else if (fn == -1)
            begin
                shadow_mapped[rq.page] = 1'b0;
                shadow_frame[rq.page]  = '0;
            end
            else if (fn < -1 || fn >= int'(shadow_frame_count))
                rs.status = STATUS_REJECTED;
            else
            begin
                // The whole table is searched, not only the pages below page_count.
                clash = 1'b0;
                for (int k = 0; k < DEPTH; k++)
                    if (k != rq.page && shadow_mapped[k] && int'(shadow_frame[k]) == fn)
                        clash = 1'b1;
                if (clash)
                    rs.status = STATUS_REJECTED;
                else
                begin
                    shadow_mapped[rq.page] = 1'b1;
                    shadow_frame[rq.page]  = fn[FRAME_W-1:0];
                end
            end
        end
        else
        begin
            if (shadow_page_size == 0)
                rs.status = STATUS_INVALID;
            else
            begin
                pn = rq.va / shadow_page_size;
                if (pn >= lim)
                    rs.status = STATUS_INVALID;
                else if (!shadow_mapped[pn])
                    rs.status = STATUS_FAULT;
                else
                begin
                    phys = 32'(shadow_frame[pn]);
                    phys = phys * shadow_page_size + rq.va % shadow_page_size;
                    rs.status  = STATUS_TRANSLATED;
                    rs.address = phys[PA_W-1:0];
                end
            end
        end
        return rs;
    endfunction

    function automatic pt_request_t map_item(input int unsigned page, input int frame);
        pt_request_t rq;
        rq.op    = OP_MAP;
        rq.page  = page[PAGE_W-1:0];
        rq.frame = frame[FNUM_W-1:0];
        rq.va    = VA_W'($urandom);
        return rq;
    endfunction

    function automatic pt_request_t xlate_item(input int unsigned va);
        pt_request_t rq;
        rq.op    = OP_TRANSLATE;
        rq.page  = PAGE_W'($urandom);
        rq.frame = FNUM_W'($urandom);
        rq.va    = va[VA_W-1:0];
        return rq;
    endfunction

    // Random transaction for the current geometry. Most writes land on pages in range with
    // frames in range, so the table fills and duplicates turn up; most translations aim at
    // pages in range, often ones written recently, so that mapped pages are actually hit.
    function automatic pt_request_t random_request();
        pt_request_t rq;
        int unsigned lim;
        int unsigned fc;
        int unsigned pn;
        int unsigned addr;
        int unsigned pick;
        lim = (shadow_page_count > DEPTH) ? DEPTH : shadow_page_count;
        fc  = (shadow_frame_count > DEPTH) ? DEPTH : shadow_frame_count;
        rq.op    = OP_MAP;
        rq.page  = PAGE_W'($urandom);
        rq.frame = FNUM_W'($urandom);
        rq.va    = VA_W'($urandom);
        if ($urandom_range(0, 99) < 45)
        begin
            if (lim != 0 && $urandom_range(0, 99) < 85)
                rq.page = PAGE_W'($urandom_range(0, lim - 1));
            pick = $urandom_range(0, 99);
            if (pick < 10)
                rq.frame = FRAME_UNMAPPED;
            else if (pick >= 20 && fc != 0)
                rq.frame = FNUM_W'($urandom_range(0, fc - 1));
            if (rq.page < lim && $signed(rq.frame) >= 0)
            begin
                touched_pages.push_back(32'(rq.page));
                if (touched_pages.size() > 32)
                    void'(touched_pages.pop_front());
            end
        end
        else
        begin
            rq.op = OP_TRANSLATE;
            if ($urandom_range(0, 99) < 70 && shadow_page_size != 0 && lim != 0)
            begin
                if (touched_pages.size() != 0 && $urandom_range(0, 2) != 0)
                    pn = touched_pages[$urandom_range(0, touched_pages.size() - 1)];
                else
                    pn = $urandom_range(0, lim - 1);
                addr = pn * shadow_page_size + $urandom_range(0, shadow_page_size - 1);
                if (addr <= 32'hFFFF)
                    rq.va = addr[VA_W-1:0];
            end
        end
        return rq;
    endfunction

    // Request driver. The expectation is formed at the edge where the transaction is taken,
    // so the shadow table advances in exactly the order the block sees the requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                next_req.op    = req_ch.operation;
                next_req.page  = req_ch.page_index;
                next_req.frame = req_ch.frame_number;
                next_req.va    = req_ch.virtual_address;
                awaited_responses.push_back(predict_response(next_req));
            end
            // The payload may only change once the current transaction has gone.
            if (!req_ch.valid || req_ch.ready)
            begin
                if (src_idle_left > 0)
                begin
                    src_idle_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (idling_on && $urandom_range(0, 5) == 0)
                begin
                    src_idle_left = $urandom_range(1, 17) - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    next_req = request_backlog.pop_front();
                    req_ch.operation       <= next_req.op;
                    req_ch.page_index      <= next_req.page;
                    req_ch.frame_number    <= next_req.frame;
                    req_ch.virtual_address <= next_req.va;
                    req_ch.valid           <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_responses.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: status %0d addr %h",
                                              res_ch.status, res_ch.physical_address));
                else
                begin
                    wanted = awaited_responses.pop_front();
                    if (res_ch.status !== wanted.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  res_ch.status, wanted.status));
                    if (res_ch.physical_address !== wanted.address)
                        report_mismatch($sformatf("physical address %h, expected %h",
                                                  res_ch.physical_address, wanted.address));
                end
            end
            if (snk_idle_left > 0)
            begin
                snk_idle_left--;
                res_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                snk_idle_left = $urandom_range(1, 17) - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped by the cycle limit, %0d results outstanding",
                     awaited_responses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // A register write lasts one clock; the caller lowers the enable after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_PAGE_SIZE:   shadow_page_size   = data[PSIZE_W-1:0];
            CFG_PAGE_COUNT:  shadow_page_count  = data[PCOUNT_W-1:0];
            CFG_FRAME_COUNT: shadow_frame_count = data[FCOUNT_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic set_geometry(input logic [PSIZE_W-1:0] ps, input logic [PCOUNT_W-1:0] pc,
                                input logic [FCOUNT_W-1:0] fc);
        write_reg(CFG_PAGE_SIZE, ps);
        write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(pc));
        write_reg(CFG_FRAME_COUNT, CFG_DATA_W'(fc));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Idle means nothing queued, nothing offered and every result back. The check is made on
    // the falling edge so that it never races the driver's rising-edge updates.
    task automatic await_idle();
        @(negedge clk);
        while (request_backlog.size() != 0 || req_ch.valid || awaited_responses.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_phase(input int n, input logic [PSIZE_W-1:0] ps,
                                input logic [PCOUNT_W-1:0] pc, input logic [FCOUNT_W-1:0] fc);
        set_geometry(ps, pc, fc);
        touched_pages.delete();
        @(negedge clk);
        repeat (n) request_backlog.push_back(random_request());
        await_idle();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_write              = 1'b0;
        cfg_index              = CFG_PAGE_SIZE;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.operation       = OP_MAP;
        req_ch.page_index      = '0;
        req_ch.frame_number    = '0;
        req_ch.virtual_address = '0;
        res_ch.ready           = 1'b0;
        for (int k = 0; k < DEPTH; k++)
        begin
            shadow_mapped[k] = 1'b0;
            shadow_frame[k]  = '0;
        end
        shadow_page_size   = PAGE_SIZE_RESET;
        shadow_page_count  = PAGE_COUNT_RESET;
        shadow_frame_count = FRAME_COUNT_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed checks under the reset geometry. The block is still clearing its table
        // for a while; the driver simply waits for ready.
        request_backlog.push_back(xlate_item(16'h0000));    // fresh table: page fault
        request_backlog.push_back(map_item(0, 255));        // highest frame
        request_backlog.push_back(xlate_item(16'h00FF));    // last byte of that frame
        request_backlog.push_back(map_item(255, 0));        // highest page, lowest frame
        request_backlog.push_back(xlate_item(16'hFFFF));    // highest address
        request_backlog.push_back(map_item(1, 255));        // duplicate of page 0
        request_backlog.push_back(map_item(0, 255));        // rewriting the same frame
        request_backlog.push_back(map_item(2, -2));         // frame below the unmapped marker
        request_backlog.push_back(map_item(2, -256));       // most negative frame
        request_backlog.push_back(map_item(0, -1));         // unmapping
        request_backlog.push_back(xlate_item(16'h0010));    // fault after unmapping
        request_backlog.push_back(map_item(1, 255));        // frame is free again
        request_backlog.push_back(xlate_item(16'h0180));
        await_idle();

        // One page, sixteen frames. Page 255 still holds frame 0 above the lowered page
        // count, and the duplicate search must still see it.
        set_geometry(16'd256, 9'd1, 9'd16);
        @(negedge clk);
        request_backlog.push_back(map_item(5, 3));          // page beyond the page count
        request_backlog.push_back(map_item(0, 0));          // duplicate above page_count
        request_backlog.push_back(map_item(0, 16));         // frame not below frame_count
        request_backlog.push_back(map_item(0, 15));
        request_backlog.push_back(xlate_item(16'h0105));    // page number beyond the page count
        request_backlog.push_back(xlate_item(16'h0042));
        await_idle();

        // A write to the spare index is ignored; then a zero page size.
        write_reg(CFG_SPARE, 16'hFFFF);
        set_geometry(16'd0, 9'd256, 9'd256);
        @(negedge clk);
        request_backlog.push_back(xlate_item(16'h1234));
        request_backlog.push_back(xlate_item(16'h0000));
        request_backlog.push_back(map_item(7, 200));
        await_idle();

        // Random traffic over the extremes of the geometry first, then random settings.
        random_phase(155, 16'd1, 9'd256, 9'd256);
        random_phase(155, 16'hFFFF, 9'd1, 9'd256);
        random_phase(30, 16'd0, 9'd256, 9'd256);
        random_phase(155, 16'd100, 9'd200, 9'd16);
        random_phase(155, 16'd256, 9'd256, 9'd1);
        random_phase(155, 16'd3, 9'd300, 9'd511);
        random_phase(30, 16'd256, 9'd0, 9'd0);
        for (int p = 0; p < 6; p++)
        begin
            idling_on = ($urandom_range(0, 3) != 0);
            random_phase(155,
                         PSIZE_W'($urandom_range(0, 1) ? $urandom_range(1, 1024)
                                                       : $urandom_range(1, 65535)),
                         PCOUNT_W'($urandom_range(1, 256)),
                         FCOUNT_W'($urandom_range(1, 256)));
        end

        // Last stretch runs at full rate on both sides.
        idling_on = 1'b0;
        random_phase(155, 16'd512, 9'd128, 9'd256);

        // A full duplicate scan is the longest job the block can have in hand.
        repeat (DEPTH + 40) @(posedge clk);
        if (awaited_responses.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_responses.size()));

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
